### rtl/core/fac_pkg.sv
// ============================================================================
// fac_pkg
// Shared constants and types for the FIR audio filter.
// ============================================================================
package fac_pkg;

    localparam int MAX_TAPS  = 64;
    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 16;
    localparam int TAP_IDX_W = 6;
    localparam int CFG_W     = 7;
    localparam int FRAC_W    = COEF_W - 1;
    localparam int PROD_W    = SAMPLE_W + COEF_W;
    localparam int CNT_W     = $clog2(MAX_TAPS);
    localparam int NTAP_W    = $clog2(MAX_TAPS + 1);
    localparam int CMP_W     = (NTAP_W > CFG_W) ? NTAP_W : CFG_W;
    localparam int ACC_W     = PROD_W + NTAP_W;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(64);

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_COEF   = 1'b1;

    typedef struct packed {
        logic shift;
        logic rotate;
    } cell_ctrl_t;

    typedef struct packed {
        logic clear;
        logic take;
        logic tap_ok;
    } mac_ctrl_t;

endpackage

### rtl/core/fac_if.sv
// ============================================================================
// fac_if
// Valid/ready channels of the FIR audio filter: input, result, config.
// ============================================================================
interface fac_in_if
    import fac_pkg::*;
();
    logic                        valid;
    logic                        ready;
    logic                        kind;
    logic signed [SAMPLE_W-1:0]  sample_in;
    logic [TAP_IDX_W-1:0]        tap_index;
    logic signed [COEF_W-1:0]    tap_value;

    modport source (output valid, kind, sample_in, tap_index, tap_value, input ready);
    modport sink   (input valid, kind, sample_in, tap_index, tap_value, output ready);
endinterface

interface fac_out_if
    import fac_pkg::*;
();
    logic                        valid;
    logic                        ready;
    logic signed [SAMPLE_W-1:0]  sample_out;
    logic                        clipped;

    modport source (output valid, sample_out, clipped, input ready);
    modport sink   (input valid, sample_out, clipped, output ready);
endinterface

interface fac_cfg_if
    import fac_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CFG_W-1:0]  active_taps;

    modport source (output valid, active_taps, input ready);
    modport sink   (input valid, active_taps, output ready);
endinterface

### rtl/core/fac_cell.sv
// ============================================================================
// fac_cell
// One tap cell: holds a history sample and its coefficient; shifts the
// sample down the line or rotates the pair toward the MAC end.
// ============================================================================
module fac_cell
    import fac_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  cell_ctrl_t                 ctrl,
    input  logic                       wr_en,
    input  logic signed [COEF_W-1:0]   wr_coef,
    input  logic signed [SAMPLE_W-1:0] prev_sample,
    input  logic signed [SAMPLE_W-1:0] next_sample,
    input  logic signed [COEF_W-1:0]   next_coef,
    output logic signed [SAMPLE_W-1:0] sample,
    output logic signed [COEF_W-1:0]   coef
);

    logic signed [SAMPLE_W-1:0] sample_reg;
    logic signed [SAMPLE_W-1:0] sample_next;
    logic signed [COEF_W-1:0]   coef_reg;
    logic signed [COEF_W-1:0]   coef_next;

    always_comb
    begin
        sample_next = sample_reg;
        coef_next   = coef_reg;
        if (ctrl.shift)
        begin
            sample_next = prev_sample;
        end
        else if (ctrl.rotate)
        begin
            sample_next = next_sample;
        end
        if (wr_en)
        begin
            coef_next = wr_coef;
        end
        else if (ctrl.rotate)
        begin
            coef_next = next_coef;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_reg <= '0;
            coef_reg   <= '0;
        end
        else
        begin
            sample_reg <= sample_next;
            coef_reg   <= coef_next;
        end
    end

    assign sample = sample_reg;
    assign coef   = coef_reg;

endmodule

### rtl/core/fac_mac.sv
// ============================================================================
// fac_mac
// Multiply-accumulate at the head of the cell ring, with round-to-nearest
// and saturation of the Q.15 sum to 16 bits.
// ============================================================================
module fac_mac
    import fac_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  mac_ctrl_t                  ctrl,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic signed [COEF_W-1:0]   coef,
    output logic signed [SAMPLE_W-1:0] sample_out,
    output logic                       clipped
);

    localparam logic signed [ACC_W-1:0] ROUND_ADD = ACC_W'(2 ** (FRAC_W - 1));
    localparam logic signed [ACC_W-1:0] LIM_POS   = ACC_W'(2 ** (SAMPLE_W + FRAC_W - 1));
    localparam logic signed [ACC_W-1:0] LIM_NEG   = -LIM_POS;
    localparam logic signed [SAMPLE_W-1:0] SAT_POS = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAT_NEG = {1'b1, {(SAMPLE_W-1){1'b0}}};

    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_ok_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  rnd;
    logic signed [ACC_W-1:0]  quo;

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.clear)
        begin
            acc_next = '0;
        end
        else if (prod_ok_reg)
        begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_ok_reg <= 1'b0;
            acc_reg     <= '0;
        end
        else
        begin
            prod_ok_reg <= ctrl.take & ctrl.tap_ok & ~ctrl.clear;
            acc_reg     <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= sample * coef;
    end

    always_comb
    begin
        rnd = acc_reg + ROUND_ADD;
        quo = rnd >>> FRAC_W;
        if (rnd >= LIM_POS)
        begin
            sample_out = SAT_POS;
            clipped    = 1'b1;
        end
        else if (rnd < LIM_NEG)
        begin
            sample_out = SAT_NEG;
            clipped    = 1'b1;
        end
        else
        begin
            sample_out = quo[SAMPLE_W-1:0];
            clipped    = 1'b0;
        end
    end

endmodule

### rtl/core/fir_audio_filter.sv
// ============================================================================
// fir_audio_filter
// Direct-form FIR filter for 16-bit audio built as a ring of tap cells.
// ============================================================================
// Channels: samples (input words), results (output words), cfg (tap count).
// A samples word with kind 0 shifts sample_in into the history and yields
// one results word; kind 1 writes tap_value into tap tap_index, no result.
// cfg writes active_taps (1..64, 0 acts as 1, larger acts as 64); cfg.ready
// is always high, write only while the filter is idle.
// After a sample word is accepted, the cell ring rotates once past the
// single multiply-accumulate unit, one tap per cycle; the product register
// then drains into the accumulator (drain step) and the rounded sum goes
// to the output register (emit step). A coefficient word is written on
// acceptance. samples.ready is high only when idle.
// The result sits in an output register; a new word is accepted while it
// waits. If the receiver stalls, the next sum waits until the register
// frees, holding samples.ready low.
// Reset clears history, coefficients, and sets active_taps to 64.
// ============================================================================
module fir_audio_filter
    import fac_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    fac_in_if.sink         samples,
    fac_out_if.source      results,
    fac_cfg_if.sink        cfg
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic [CFG_W-1:0]  active_taps_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic signed [SAMPLE_W-1:0] out_sample_reg;
    logic              out_clip_reg;

    logic              in_acc;
    logic              smp_acc;
    logic              coef_acc;
    logic              emit;
    logic [CMP_W-1:0]  taps_w;
    logic [CMP_W-1:0]  n_eff;

    cell_ctrl_t        cell_ctrl;
    mac_ctrl_t         mac_ctrl;
    logic signed [SAMPLE_W-1:0] mac_sample;
    logic              mac_clip;

    logic signed [SAMPLE_W-1:0] cell_sample [MAX_TAPS];
    logic signed [COEF_W-1:0]   cell_coef   [MAX_TAPS];

    assign samples.ready = (state_reg == ST_IDLE);
    assign cfg.ready     = 1'b1;

    assign in_acc   = samples.valid & samples.ready;
    assign smp_acc  = in_acc & (samples.kind == KIND_SAMPLE);
    assign coef_acc = in_acc & (samples.kind == KIND_COEF);
    assign emit     = (state_reg == ST_EMIT) & (~out_valid_reg | results.ready);

    always_comb
    begin
        taps_w = CMP_W'(active_taps_reg);
        if (taps_w == '0)
        begin
            n_eff = CMP_W'(1);
        end
        else if (taps_w > CMP_W'(MAX_TAPS))
        begin
            n_eff = CMP_W'(MAX_TAPS);
        end
        else
        begin
            n_eff = taps_w;
        end
    end

    assign cell_ctrl.shift  = smp_acc;
    assign cell_ctrl.rotate = (state_reg == ST_RUN);

    assign mac_ctrl.clear  = smp_acc;
    assign mac_ctrl.take   = (state_reg == ST_RUN);
    assign mac_ctrl.tap_ok = (CMP_W'(cnt_reg) < n_eff);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (smp_acc)
                begin
                    state_next = ST_RUN;
                    cnt_next   = '0;
                end
            end
            ST_RUN:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(MAX_TAPS - 1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (emit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cnt_reg         <= '0;
            active_taps_reg <= CFG_RESET;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid & cfg.ready)
            begin
                active_taps_reg <= cfg.active_taps;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_sample_reg <= mac_sample;
            out_clip_reg   <= mac_clip;
        end
    end

    assign results.valid      = out_valid_reg;
    assign results.sample_out = out_sample_reg;
    assign results.clipped    = out_clip_reg;

    genvar k;
    generate
        for (k = 0; k < MAX_TAPS; k++)
        begin : g_cell
            logic                       wr_hit;
            logic signed [SAMPLE_W-1:0] prev_s;
            logic signed [SAMPLE_W-1:0] next_s;
            logic signed [COEF_W-1:0]   next_c;

            assign wr_hit = coef_acc & (32'(samples.tap_index) == k);

            if (k == 0)
            begin : g_head
                assign prev_s = samples.sample_in;
            end
            else
            begin : g_body
                assign prev_s = cell_sample[k-1];
            end

            if (k == MAX_TAPS - 1)
            begin : g_tail
                assign next_s = cell_sample[0];
                assign next_c = cell_coef[0];
            end
            else
            begin : g_link
                assign next_s = cell_sample[k+1];
                assign next_c = cell_coef[k+1];
            end

            fac_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (cell_ctrl),
                .wr_en       (wr_hit),
                .wr_coef     (samples.tap_value),
                .prev_sample (prev_s),
                .next_sample (next_s),
                .next_coef   (next_c),
                .sample      (cell_sample[k]),
                .coef        (cell_coef[k])
            );
        end
    endgenerate

    fac_mac u_mac (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (mac_ctrl),
        .sample     (cell_sample[0]),
        .coef       (cell_coef[0]),
        .sample_out (mac_sample),
        .clipped    (mac_clip)
    );

`ifndef ASSERT_OFF
    a_run_enters: assert property (@(posedge clk) disable iff (!rst_n)
        smp_acc |=> (state_reg == ST_RUN) && (cnt_reg == '0))
        else $error("sample word did not start the ring pass");

    a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) && (cnt_reg == CNT_W'(MAX_TAPS - 1)) |=>
        (state_reg == ST_DRAIN))
        else $error("ring pass did not end after one full rotation");

    a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_EMIT))
        else $error("result word raised outside the emit step");

    a_no_rotate_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cell_ctrl.rotate |-> !samples.ready)
        else $error("ring rotating while input is open");
`endif

endmodule
